### hdl/spq_pkg.sv
// spq_pkg: shared types, codes and constants of the sorted-array priority queue
// used by spq_ctrl, spq_datapath and sorted_array_priority_queue_top; no dependencies

package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int COUNT_W   = 11;
	localparam int STATUS_W  = 2;

	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_EXTRACT = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted operation
		logic execute;   // run the operation on the cell row, load the result
	} dp_cmd_t;

endpackage

### hdl/sorted_array_priority_queue_top.sv
// sorted_array_priority_queue_top: max priority queue over a sorted row of signed keys
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//  channel  dir  tdata                          tuser
//  s_*      in   key_in[31:0]                   command (0 insert, 1 extract)
//  m_*      out  key_out[31:0], count[42:32]    status (0 done, 1 full, 2 empty)
//
// each operation first captures the transfer, then every
// cell of the key row compares against the new key and shifts in parallel
// execution waits while the held result is not taken
// a new input transfer is accepted while the previous result still waits
// arst_n clears the count and the handshake state; key cells are not reset

module sorted_array_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] key_in
	input  logic        s_tuser,    // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [31:0] key_out, [42:32] count, rest zero
	output logic [1:0]  m_tuser     // [1:0] status
);

	spq_pkg::dp_cmd_t                   dp_cmd;
	logic signed [spq_pkg::KEY_W-1:0]   key_out;
	logic [spq_pkg::COUNT_W-1:0]        count;

	// handshakes and sequencing
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_cmd   (dp_cmd)
	);

	// key row, count and result register
	spq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.in_cmd     (s_tuser),
		.in_key     (s_tdata),
		.out_status (m_tuser),
		.out_key    (key_out),
		.out_count  (count)
	);

	assign m_tdata = {5'd0, count, key_out};

endmodule

### hdl/spq_ctrl.sv
// spq_ctrl: controller state machine of the priority queue, handshakes of both channels
// depends on spq_pkg

module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output spq_pkg::dp_cmd_t dp_cmd
);

	spq_pkg::fsm_t state_q, state_next;
	logic          m_tvalid_q;
	logic          out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= spq_pkg::FSM_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (dp_cmd.execute) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next     = state_q;
		s_tready       = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.execute = 1'b0;
		unique case (state_q)
			spq_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					dp_cmd.capture = 1'b1;
					state_next     = spq_pkg::FSM_EXEC;
				end
			end
			spq_pkg::FSM_EXEC: begin
				// wait here while the previous result is still held
				if (out_free) begin
					dp_cmd.execute = 1'b1;
					state_next     = spq_pkg::FSM_IDLE;
				end
			end
			default: state_next = spq_pkg::FSM_IDLE;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.execute |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten while held");

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.capture |=> (state_q == spq_pkg::FSM_EXEC))
		else $error("accepted operation not taken to execution");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.execute |=> m_tvalid)
		else $error("execution did not present a result");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spq_pkg::FSM_EXEC) |-> !s_tready)
		else $error("input accepted while an operation is pending");

endmodule

### hdl/spq_datapath.sv
// spq_datapath: row of key cells with per-cell compare and shift, entry count, result register
// depends on spq_pkg

module spq_datapath #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spq_pkg::dp_cmd_t                    dp_cmd,
	input  logic                                in_cmd,
	input  logic signed [spq_pkg::KEY_W-1:0]    in_key,
	output logic [spq_pkg::STATUS_W-1:0]        out_status,
	output logic signed [spq_pkg::KEY_W-1:0]    out_key,
	output logic [spq_pkg::COUNT_W-1:0]         out_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic                              cmd_q;
	logic signed [spq_pkg::KEY_W-1:0]  key_q;
	logic signed [spq_pkg::KEY_W-1:0]  entry_q [DEPTH];
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_next;
	logic                              full, empty;
	logic                              do_insert, do_extract;
	logic [DEPTH-1:0]                  below;   // key goes at or above this cell
	spq_pkg::status_t                  status_c;

	logic [spq_pkg::STATUS_W-1:0]      status_q;
	logic signed [spq_pkg::KEY_W-1:0]  key_out_q;
	logic [spq_pkg::COUNT_W-1:0]       count_out_q;

	assign full       = (count_q == DEPTH_C);
	assign empty      = (count_q == '0);
	assign do_insert  = dp_cmd.execute && (cmd_q == spq_pkg::CMD_INSERT) && !full;
	assign do_extract = dp_cmd.execute && (cmd_q == spq_pkg::CMD_EXTRACT) && !empty;

	always_comb begin
		count_next = count_q;
		status_c   = spq_pkg::ST_DONE;
		if (cmd_q == spq_pkg::CMD_INSERT) begin
			if (full) status_c = spq_pkg::ST_FULL;
			else      count_next = count_q + CW'(1);
		end else begin
			if (empty) status_c = spq_pkg::ST_EMPTY;
			else       count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
		end
	end

	// each cell compares the new key with its own entry; cells past the count
	// count as below so the first free cell takes the key
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			localparam logic [CW-1:0] IDX = CW'(i);
			logic signed [spq_pkg::KEY_W-1:0] ins_val, ext_val;

			assign below[i] = (IDX < count_q) ? (key_q > entry_q[i]) : 1'b1;

			if (i == 0) begin : g_head
				assign ins_val = key_q;
			end else begin : g_body
				assign ins_val = below[i-1] ? entry_q[i-1] : key_q;
			end

			if (i < DEPTH - 1) begin : g_shift
				assign ext_val = entry_q[i+1];
			end else begin : g_tail
				assign ext_val = entry_q[i];
			end

			always_ff @(posedge clk) begin
				if (do_insert && below[i]) begin
					entry_q[i] <= ins_val;
				end else if (do_extract) begin
					entry_q[i] <= ext_val;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.execute) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.execute) begin
			status_q    <= status_c;
			key_out_q   <= do_extract ? entry_q[0] : '0;
			count_out_q <= spq_pkg::COUNT_W'(count_next);
		end
	end

	assign out_status = status_q;
	assign out_key    = key_out_q;
	assign out_count  = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count past depth");

	a_refuse_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.execute && !do_insert && !do_extract) |=> $stable(count_q))
		else $error("refused operation changed the count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the count");

endmodule

### dv/sorted_array_priority_queue_top_tb.sv
// sorted_array_priority_queue_top_tb: self-checking bench for the sorted-array max priority queue
// depends on spq_pkg and sorted_array_priority_queue_top; keeps its own shadow of the key row
// and checks every result transfer against it while both stream sides idle and stall at random

module sorted_array_priority_queue_top_tb;

	localparam int QDEPTH     = spq_pkg::DEPTH_DEF;
	localparam int MAX_REPORT = 10;
	localparam int DRAIN_WAIT = 20;

	// how often a side inserts idle cycles between its transfers
	typedef enum int {
		PACE_FULL_SPEED,
		PACE_SPARSE,
		PACE_RANDOM
	} pace_t;

	// one expected result transfer
	typedef struct {
		spq_pkg::status_t               status;
		logic [spq_pkg::KEY_W-1:0]      key;
		logic [spq_pkg::COUNT_W-1:0]    count;
	} queue_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	// shadow of the queue: largest key at index 0
	logic [spq_pkg::KEY_W-1:0] sorted_keys [QDEPTH];
	int                        key_count = 0;

	queue_result_t pending_results[$];
	int            mismatches = 0;

	pace_t tx_pace     = PACE_RANDOM;
	pace_t rx_pace     = PACE_RANDOM;
	int    hold_cycles = 0;

	sorted_array_priority_queue_top #(
		.DEPTH(QDEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// applies one operation to the shadow queue and returns the result it must produce
	function automatic queue_result_t queue_op_result(spq_pkg::cmd_t op,
			logic [spq_pkg::KEY_W-1:0] key);
		queue_result_t res;
		int            pos;
		res.status = spq_pkg::ST_DONE;
		res.key    = '0;
		if (op == spq_pkg::CMD_INSERT) begin
			if (key_count >= QDEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				// walk the new key up past every strictly smaller key
				pos = key_count;
				while (pos > 0 && $signed(key) > $signed(sorted_keys[pos-1])) begin
					sorted_keys[pos] = sorted_keys[pos-1];
					pos--;
				end
				sorted_keys[pos] = key;
				key_count++;
			end
		end else begin
			if (key_count == 0) begin
				res.status = spq_pkg::ST_EMPTY;
			end else begin
				res.key = sorted_keys[0];
				for (int i = 0; i + 1 < key_count; i++) begin
					sorted_keys[i] = sorted_keys[i+1];
				end
				key_count--;
			end
		end
		res.count = spq_pkg::COUNT_W'(key_count);
		return res;
	endfunction

	function automatic int idle_cycles(pace_t pace);
		case (pace)
			PACE_FULL_SPEED: return 0;
			PACE_SPARSE:     return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
			default:         return $urandom_range(0, 17);
		endcase
	endfunction

	// keys: extremes, a narrow band around zero for duplicates, and full-range values
	function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
		logic [spq_pkg::KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0:       k = 32'h7fff_ffff;
			1:       k = 32'h8000_0000;
			2, 3:    k = 32'($urandom_range(0, 8)) - 32'd4;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// result checking and prediction share one process so both see the same edge
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					if (mismatches < MAX_REPORT)
						$display("%0t: unexpected result: status %0d key %h count %0d",
							$realtime, m_tuser, m_tdata[31:0], m_tdata[42:32]);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.status || m_tdata[31:0] !== want.key ||
							m_tdata[42:32] !== want.count) begin
						if (mismatches < MAX_REPORT)
							$display("%0t: want st %0d key %h cnt %0d, got st %0d key %h cnt %0d",
								$realtime, want.status, want.key, want.count,
								m_tuser, m_tdata[31:0], m_tdata[42:32]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(queue_op_result(spq_pkg::cmd_t'(s_tuser), s_tdata));
		end
	end

	// receiver: a random stall before each result, plus a long hold-off on request
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = idle_cycles(rx_pace);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// one operation, held until the transfer; tvalid stays high if no gap follows
	task automatic send_op(spq_pkg::cmd_t op, logic [spq_pkg::KEY_W-1:0] key);
		int gap;
		gap = idle_cycles(tx_pace);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// empty refusal, field extremes, duplicates and ordering of signed keys
	task automatic test_empty_and_extremes();
		tx_pace = PACE_RANDOM;
		rx_pace = PACE_RANDOM;
		send_op(spq_pkg::CMD_EXTRACT, 32'hffff_ffff);
		send_op(spq_pkg::CMD_INSERT,  32'h0000_0000);
		send_op(spq_pkg::CMD_INSERT,  32'h7fff_ffff);
		send_op(spq_pkg::CMD_INSERT,  32'h8000_0000);
		send_op(spq_pkg::CMD_INSERT,  32'hffff_ffff);
		send_op(spq_pkg::CMD_INSERT,  32'h0000_0001);
		send_op(spq_pkg::CMD_INSERT,  32'h0000_0000);
		send_op(spq_pkg::CMD_INSERT,  32'h7fff_ffff);
		for (int i = 0; i < 8; i++)
			send_op(spq_pkg::CMD_EXTRACT, 32'h5555_aaaa);
		send_op(spq_pkg::CMD_EXTRACT, 32'h0000_0000);
		wait_drained();
	endtask

	// well-formed fill to full with refusals, then drain past empty
	task automatic test_fill_and_drain(int rounds);
		for (int r = 0; r < rounds; r++) begin
			tx_pace = pace_t'($urandom_range(0, 2));
			rx_pace = pace_t'($urandom_range(0, 2));
			for (int i = 0; i < QDEPTH + 2; i++)
				send_op(spq_pkg::CMD_INSERT, pick_key());
			for (int i = 0; i < QDEPTH + 2; i++)
				send_op(spq_pkg::CMD_EXTRACT, $urandom);
		end
		wait_drained();
	endtask

	// mixed operations in runs with a biased insert rate so the fill level wanders
	task automatic test_random_traffic(int runs, int run_len);
		int insert_pct;
		for (int r = 0; r < runs; r++) begin
			tx_pace    = pace_t'($urandom_range(0, 2));
			rx_pace    = pace_t'($urandom_range(0, 2));
			insert_pct = 20 + 30 * $urandom_range(0, 2);
			for (int i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 99) < insert_pct)
					send_op(spq_pkg::CMD_INSERT, pick_key());
				else
					send_op(spq_pkg::CMD_EXTRACT, $urandom);
			end
		end
		wait_drained();
	endtask

	// receiver holds off for a long stretch while the sender keeps pushing
	task automatic test_output_stall();
		tx_pace     = PACE_FULL_SPEED;
		rx_pace     = PACE_FULL_SPEED;
		hold_cycles = 80;
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_op(spq_pkg::CMD_EXTRACT, pick_key());
			else
				send_op(spq_pkg::CMD_INSERT, pick_key());
		end
		wait_drained();
		rx_pace = PACE_RANDOM;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_fill_and_drain(4);
		test_output_stall();
		test_random_traffic(15, 40);
		test_output_stall();
		test_fill_and_drain(2);
		test_random_traffic(3, 40);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
